// ===== rtl/core/hbm_pkg.sv =====
// Shared types, codes and constants for the node health heartbeat and LED monitor.
package hbm_pkg;

   // Width of the internal heartbeat counter; the response carries its low eight bits.
   localparam int COUNTER_BITS = 8;
   localparam int BEAT_OUT_BITS = 8;

   // Command codes carried by a request.
   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_SET_STATE = 3'd1,
      CMD_SET_WARN  = 3'd2,
      CMD_CLR_WARN  = 3'd3,
      CMD_SET_ERR   = 3'd4,
      CMD_CLR_ERR   = 3'd5
   } command_type;

   // Node states.
   typedef enum logic [1:0] {
      ST_INIT  = 2'd0,
      ST_OK    = 2'd1,
      ST_ERROR = 2'd2,
      ST_OTHER = 2'd3
   } node_mode_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_HB_INTERVAL = 3'd0,
      CSR_SLOW_BLINK  = 3'd1,
      CSR_MED_BLINK   = 3'd2,
      CSR_FAST_BLINK  = 3'd3,
      CSR_GPS_MASK    = 3'd4,
      CSR_IMU_MASK    = 3'd5,
      CSR_LINK_MASK   = 3'd6
   } csr_index_type;

   // Configuration register file contents.
   typedef struct packed {
      logic [15:0] heartbeat_interval_ms;
      logic [15:0] slow_blink_ms;
      logic [15:0] medium_blink_ms;
      logic [15:0] fast_blink_ms;
      logic [15:0] gps_nofix_mask;
      logic [15:0] imu_nofix_mask;
      logic [15:0] link_fail_mask;
   } cfg_type;

   // One request as held in the input register.
   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] now_ms;
      logic [1:0]  new_state;
      logic [15:0] bits;
      logic        link_fail;
   } request_type;

   // Monitor state carried from one request to the next.
   typedef struct packed {
      node_mode_type           mode;
      logic [COUNTER_BITS-1:0] counter;
      logic [15:0]             warning_word;
      logic [15:0]             error_word;
      logic [31:0]             last_beat_time;
      logic [31:0]             last_toggle_time;
      logic                    led_level;
   } monitor_state_type;

   // Low eight bits of the counter, zero extended when the counter is narrower.
   function automatic logic [BEAT_OUT_BITS-1:0] beat_out(input logic [COUNTER_BITS-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[BEAT_OUT_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/hbm_step.sv =====
// Next-state logic of the monitor for one request.
module hbm_step import hbm_pkg::*; (
   input  monitor_state_type cur,
   input  cfg_type           cfg,
   input  request_type       req,
   output monitor_state_type nxt,
   output logic              beat
);

   logic          state_change;
   logic          periodic_beat;
   node_mode_type target_mode;
   node_mode_type tick_mode;
   logic [15:0]   warn_mid;
   logic [15:0]   fail_bits;
   logic          gps_fix;
   logic          imu_fix;
   logic [15:0]   blink_period;
   logic [31:0]   beat_elapsed;
   logic [31:0]   toggle_elapsed;

   // Tick: error bits force the error state, a clean node in error recovers to ok.
   always_comb begin
      target_mode  = (cur.error_word != 16'd0) ? ST_ERROR : ST_OK;
      state_change = (cur.error_word != 16'd0) ? (cur.mode != ST_ERROR)
                                               : (cur.mode == ST_ERROR);
      tick_mode    = state_change ? target_mode : cur.mode;
      fail_bits    = req.link_fail ? cfg.link_fail_mask : 16'd0;
      // The LED sees the link-fail bits merged into the warning word after a state-change heartbeat only.
      warn_mid     = state_change ? (cur.warning_word | fail_bits) : cur.warning_word;
      beat_elapsed = req.now_ms - cur.last_beat_time;
      // After a state-change heartbeat the elapsed time is zero.
      periodic_beat = state_change ? (cfg.heartbeat_interval_ms == 16'd0)
                                   : (beat_elapsed >= 32'(cfg.heartbeat_interval_ms));
   end

   // Blink mode selection from the GPS and IMU fix bits.
   always_comb begin
      gps_fix        = (warn_mid & cfg.gps_nofix_mask) == 16'd0;
      imu_fix        = (warn_mid & cfg.imu_nofix_mask) == 16'd0;
      toggle_elapsed = req.now_ms - cur.last_toggle_time;
      if (gps_fix) begin
         blink_period = cfg.medium_blink_ms;
      end else if (imu_fix) begin
         blink_period = cfg.fast_blink_ms;
      end else begin
         blink_period = cfg.slow_blink_ms;
      end
   end

   // Command decode and state update.
   always_comb begin
      nxt  = cur;
      beat = 1'b0;
      case (req.command)
         CMD_TICK: begin
            nxt.mode    = tick_mode;
            beat        = state_change | periodic_beat;
            nxt.counter = cur.counter + COUNTER_BITS'(state_change)
                                      + COUNTER_BITS'(periodic_beat);
            if (state_change | periodic_beat) begin
               nxt.last_beat_time = req.now_ms;
               nxt.warning_word   = cur.warning_word | fail_bits;
            end
            if (tick_mode != ST_OK) begin
               nxt.led_level = 1'b0;
            end else if (gps_fix && imu_fix) begin
               nxt.led_level = 1'b1;
            end else if (toggle_elapsed >= 32'(blink_period)) begin
               nxt.led_level        = ~cur.led_level;
               nxt.last_toggle_time = req.now_ms;
            end
         end
         CMD_SET_STATE: begin
            if (req.new_state != cur.mode) begin
               nxt.mode           = node_mode_type'(req.new_state);
               beat               = 1'b1;
               nxt.counter        = cur.counter + COUNTER_BITS'(1);
               nxt.last_beat_time = req.now_ms;
               nxt.warning_word   = cur.warning_word | fail_bits;
            end
         end
         CMD_SET_WARN: nxt.warning_word = cur.warning_word | req.bits;
         CMD_CLR_WARN: nxt.warning_word = cur.warning_word & ~req.bits;
         CMD_SET_ERR:  nxt.error_word   = cur.error_word | req.bits;
         CMD_CLR_ERR:  nxt.error_word   = cur.error_word & ~req.bits;
         default: begin
            nxt  = cur;
            beat = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/health_heartbeat_led_monitor.sv =====
// Top level of the node health monitor: input register, state, result register, CSRs.
// A request accepted into the input register answers from the result register.
// Throughput: one request per cycle while rsp_ready holds; the one-pass update
// from the input register into the state and result registers sets that figure.
// Reset (synchronous, active high) returns the state to init with cleared words,
// counter and LED, and loads the configuration registers with their defaults.
module health_heartbeat_led_monitor import hbm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [31:0] req_now_ms,
   input  logic [1:0]  req_new_state,
   input  logic [15:0] req_bits,
   input  logic        req_link_fail,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_heartbeat_sent,
   output logic [7:0]  rsp_beat_count,
   output logic [1:0]  rsp_node_state,
   output logic [15:0] rsp_warning_bits,
   output logic [15:0] rsp_error_bits,
   output logic        rsp_led_lit,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   request_type       req_ff;
   logic              req_valid_ff;
   monitor_state_type state_ff;
   monitor_state_type state_in;
   logic              beat_in;
   logic              advance;
   logic              rsp_valid_ff;
   logic              rsp_beat_ff;
   logic [7:0]        rsp_count_ff;
   logic [1:0]        rsp_state_ff;
   logic [15:0]       rsp_warn_ff;
   logic [15:0]       rsp_err_ff;
   logic              rsp_led_ff;

   // Handshake: the held request moves on when the result register is free.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HB_INTERVAL: cfg_in.heartbeat_interval_ms = csr_wdata;
            CSR_SLOW_BLINK:  cfg_in.slow_blink_ms         = csr_wdata;
            CSR_MED_BLINK:   cfg_in.medium_blink_ms       = csr_wdata;
            CSR_FAST_BLINK:  cfg_in.fast_blink_ms         = csr_wdata;
            CSR_GPS_MASK:    cfg_in.gps_nofix_mask        = csr_wdata;
            CSR_IMU_MASK:    cfg_in.imu_nofix_mask        = csr_wdata;
            CSR_LINK_MASK:   cfg_in.link_fail_mask        = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.heartbeat_interval_ms <= 16'd100;
         cfg_ff.slow_blink_ms         <= 16'd1000;
         cfg_ff.medium_blink_ms       <= 16'd500;
         cfg_ff.fast_blink_ms         <= 16'd100;
         cfg_ff.gps_nofix_mask        <= 16'd1;
         cfg_ff.imu_nofix_mask        <= 16'd2;
         cfg_ff.link_fail_mask        <= 16'd4;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff.command   <= req_command;
         req_ff.now_ms    <= req_now_ms;
         req_ff.new_state <= req_new_state;
         req_ff.bits      <= req_bits;
         req_ff.link_fail <= req_link_fail;
      end
   end

   // Per-request update.
   hbm_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .req  (req_ff),
      .nxt  (state_in),
      .beat (beat_in)
   );

   // Monitor state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode             <= ST_INIT;
         state_ff.counter          <= '0;
         state_ff.warning_word     <= 16'd0;
         state_ff.error_word       <= 16'd0;
         state_ff.last_beat_time   <= 32'd0;
         state_ff.last_toggle_time <= 32'd0;
         state_ff.led_level        <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_beat_ff  <= beat_in;
         rsp_count_ff <= beat_out(state_in.counter);
         rsp_state_ff <= state_in.mode;
         rsp_warn_ff  <= state_in.warning_word;
         rsp_err_ff   <= state_in.error_word;
         rsp_led_ff   <= state_in.led_level;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_heartbeat_sent = rsp_beat_ff;
   assign rsp_beat_count     = rsp_count_ff;
   assign rsp_node_state     = rsp_state_ff;
   assign rsp_warning_bits   = rsp_warn_ff;
   assign rsp_error_bits     = rsp_err_ff;
   assign rsp_led_lit        = rsp_led_ff;

   // The heartbeat counter only moves when a request is processed.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(state_ff.counter) |-> $past(advance))
      else $error("heartbeat counter changed without a request");

   // A processed request always leaves a response waiting.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed request produced no response");

   // A heartbeat records the request time as the last beat time.
   assert property (@(posedge clock) disable iff (reset)
      advance && beat_in |=> state_ff.last_beat_time == $past(req_ff.now_ms))
      else $error("heartbeat did not record its time");

endmodule
